// File: rtl/bbd_pkg.sv
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared constants, types and register codes for the Bayer bilinear demosaic.
// ----------------------------------------------------------------------------
package bbd_pkg;

  // Line store depth and derived widths
  localparam int MAX_WIDTH  = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_CAP  = (MAX_WIDTH < 4095) ? MAX_WIDTH : 4095;
  localparam int MAX_HEIGHT = 4096;

  // Field and counter widths
  localparam int PIX_W   = 8;
  localparam int IW_W    = 12;
  localparam int IH_W    = 13;
  localparam int PH_W    = 2;
  localparam int POS_W   = ((COL_W + 1) > (IW_W + 1)) ? (COL_W + 1) : (IW_W + 1);
  localparam int ROW_W   = 13;
  localparam int OCNT_W  = 23;
  localparam int AREA_W  = IW_W + IH_W;

  // APB port
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_PATTERN_PHASE = 2'd2;

  // Reset values
  localparam logic [IW_W-1:0] RST_WIDTH  = IW_W'(640);
  localparam logic [IH_W-1:0] RST_HEIGHT = IH_W'(480);
  localparam logic [PH_W-1:0] RST_PHASE  = '0;

  // Effective frame geometry as seen by the datapath
  typedef struct packed {
    logic [IW_W-1:0]   width;   // clamped
    logic [IH_W-1:0]   height;  // clamped
    logic [PH_W-1:0]   phase;
    logic [AREA_W-1:0] area;    // width * height, registered
  } cfg_t;

  // Per-item position info produced at accept time
  typedef struct packed {
    logic [COL_W-1:0] addr;
    logic             emit;
    logic             last;
    logic             border;
    logic             blue_row;
    logic             is_green;
  } pos_info_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

endpackage

// File: rtl/bbd_in_if.sv
// ----------------------------------------------------------------------------
// bbd_in_if
// Raw pixel stream channel: valid/ready with one Bayer sample per item.
// ----------------------------------------------------------------------------
interface bbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_pixel;
  logic       blank_tick;

  modport source (output valid, output raw_pixel, output blank_tick, input ready);
  modport sink   (input valid, input raw_pixel, input blank_tick, output ready);
endinterface

// File: rtl/bbd_out_if.sv
// ----------------------------------------------------------------------------
// bbd_out_if
// Color pixel stream channel: valid/ready with RGB and an end-of-frame flag.
// ----------------------------------------------------------------------------
interface bbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_end;

  modport source (output valid, output red, output green, output blue,
                  output frame_end, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input frame_end, output ready);
endinterface

// File: rtl/bbd_cfg_regs.sv
// ----------------------------------------------------------------------------
// bbd_cfg_regs
// APB register file: frame width, height and Bayer phase, plus clamped
// geometry and the registered frame area for the datapath.
// ----------------------------------------------------------------------------
module bbd_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bbd_pkg::APB_AW-1:0]   paddr,
  input  logic [bbd_pkg::APB_DW-1:0]   pwdata,
  output logic [bbd_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output bbd_pkg::cfg_t                cfg,
  output logic                         busy
);

  logic [bbd_pkg::IW_W-1:0]   width_r;
  logic [bbd_pkg::IH_W-1:0]   height_r;
  logic [bbd_pkg::PH_W-1:0]   phase_r;
  logic [bbd_pkg::AREA_W-1:0] area_r;
  logic                       busy_r;
  logic                       wr_en;
  logic [1:0]                 reg_idx;
  logic [bbd_pkg::IW_W-1:0]   w_eff;
  logic [bbd_pkg::IH_W-1:0]   h_eff;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bbd_pkg::RST_WIDTH;
      height_r <= bbd_pkg::RST_HEIGHT;
      phase_r  <= bbd_pkg::RST_PHASE;
    end else if (wr_en) begin
      case (reg_idx)
        bbd_pkg::REG_IMAGE_WIDTH:   width_r  <= pwdata[bbd_pkg::IW_W-1:0];
        bbd_pkg::REG_IMAGE_HEIGHT:  height_r <= pwdata[bbd_pkg::IH_W-1:0];
        bbd_pkg::REG_PATTERN_PHASE: phase_r  <= pwdata[bbd_pkg::PH_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      bbd_pkg::REG_IMAGE_WIDTH:   prdata = bbd_pkg::APB_DW'(width_r);
      bbd_pkg::REG_IMAGE_HEIGHT:  prdata = bbd_pkg::APB_DW'(height_r);
      bbd_pkg::REG_PATTERN_PHASE: prdata = bbd_pkg::APB_DW'(phase_r);
      default:                    prdata = '0;
    endcase
  end

  // Saturate geometry to the supported range
  always_comb begin
    if (width_r < bbd_pkg::IW_W'(3))
      w_eff = bbd_pkg::IW_W'(3);
    else if (width_r > bbd_pkg::IW_W'(bbd_pkg::WIDTH_CAP))
      w_eff = bbd_pkg::IW_W'(bbd_pkg::WIDTH_CAP);
    else
      w_eff = width_r;

    if (height_r < bbd_pkg::IH_W'(3))
      h_eff = bbd_pkg::IH_W'(3);
    else if (height_r > bbd_pkg::IH_W'(bbd_pkg::MAX_HEIGHT))
      h_eff = bbd_pkg::IH_W'(bbd_pkg::MAX_HEIGHT);
    else
      h_eff = height_r;
  end

  // Frame area, registered from the clamped geometry
  always_ff @(posedge clk) begin
    area_r <= bbd_pkg::AREA_W'(w_eff) * bbd_pkg::AREA_W'(h_eff);
  end

  // Hold off input after reset and in the cycle after a write so area_r settles
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= wr_en;
    end
  end

  assign busy       = busy_r;
  assign cfg.width  = w_eff;
  assign cfg.height = h_eff;
  assign cfg.phase  = phase_r;
  assign cfg.area   = area_r;

endmodule

// File: rtl/bbd_line_ram.sv
// ----------------------------------------------------------------------------
// bbd_line_ram
// One line of raw samples: single write port, single registered read port.
// ----------------------------------------------------------------------------
module bbd_line_ram (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [bbd_pkg::COL_W-1:0]   rd_addr,
  output logic [bbd_pkg::PIX_W-1:0]   rd_data,
  input  logic                        wr_en,
  input  logic [bbd_pkg::COL_W-1:0]   wr_addr,
  input  logic [bbd_pkg::PIX_W-1:0]   wr_data
);

  logic [bbd_pkg::PIX_W-1:0] mem [bbd_pkg::MAX_WIDTH];

  // Read returns the old contents on a same-cycle collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// File: rtl/bbd_pos_ctrl.sv
// ----------------------------------------------------------------------------
// bbd_pos_ctrl
// Raster position tracking: column, row and output counters, emit and
// frame-end decisions, and the border/phase class of the output site.
// ----------------------------------------------------------------------------
module bbd_pos_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  bbd_pkg::cfg_t      cfg,
  output bbd_pkg::pos_info_t info
);

  localparam int PW = bbd_pkg::POS_W;

  logic [bbd_pkg::COL_W-1:0]  col_r,  col_nxt;
  logic [bbd_pkg::ROW_W-1:0]  row_r,  row_nxt;
  logic [bbd_pkg::OCNT_W-1:0] ocnt_r, ocnt_nxt;

  logic [PW-1:0]              w_x;
  logic [PW-1:0]              col_x;
  logic [PW-1:0]              col_in;
  logic [PW-1:0]              col_p1;
  logic [PW-1:0]              ox;
  logic [bbd_pkg::ROW_W-1:0]  row_in;
  logic [bbd_pkg::ROW_W-1:0]  oy;
  logic [bbd_pkg::ROW_W-1:0]  h_x;
  logic                       emit;
  logic                       last;
  logic                       border;

  assign w_x   = PW'(cfg.width);
  assign col_x = PW'(col_r);
  assign h_x   = bbd_pkg::ROW_W'(cfg.height);

  // Position of this item, wrapping a column left beyond a lowered width
  always_comb begin
    if (col_x >= w_x) begin
      col_in = '0;
      row_in = row_r + bbd_pkg::ROW_W'(1);
    end else begin
      col_in = col_x;
      row_in = row_r;
    end
    col_p1 = col_in + PW'(1);
    emit   = (row_in >= bbd_pkg::ROW_W'(2)) ||
             ((row_in == bbd_pkg::ROW_W'(1)) && (col_in != '0));
  end

  // Output site: one line plus one pixel behind
  always_comb begin
    if (col_in != '0) begin
      ox = col_in - PW'(1);
      oy = row_in - bbd_pkg::ROW_W'(1);
    end else begin
      ox = w_x - PW'(1);
      oy = row_in - bbd_pkg::ROW_W'(2);
    end
    border = (oy == '0) || (oy >= h_x - bbd_pkg::ROW_W'(1)) ||
             (ox == '0) || (ox >= w_x - PW'(1));
    last   = (bbd_pkg::AREA_W'(ocnt_r) + bbd_pkg::AREA_W'(1)) >= cfg.area;
  end

  // Counter update
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    ocnt_nxt = ocnt_r;
    if (col_p1 >= w_x) begin
      col_nxt = '0;
      row_nxt = row_in + bbd_pkg::ROW_W'(1);
    end else begin
      col_nxt = col_p1[bbd_pkg::COL_W-1:0];
      row_nxt = row_in;
    end
    if (emit) begin
      if (last) begin
        col_nxt  = '0;
        row_nxt  = '0;
        ocnt_nxt = '0;
      end else begin
        ocnt_nxt = ocnt_r + bbd_pkg::OCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ocnt_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  // Site class for the interpolator
  assign info.addr     = col_in[bbd_pkg::COL_W-1:0];
  assign info.emit     = emit;
  assign info.last     = last;
  assign info.border   = border;
  assign info.blue_row = (oy[0] == ~cfg.phase[1]);
  assign info.is_green = ((ox[0] ^ oy[0]) == ~cfg.phase[0]);

endmodule

// File: rtl/bbd_window.sv
// ----------------------------------------------------------------------------
// bbd_window
// 3x3 sample window and bilinear interpolation of the center site.
// ----------------------------------------------------------------------------
module bbd_window (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      shift_en,
  input  logic [bbd_pkg::PIX_W-1:0] top,
  input  logic [bbd_pkg::PIX_W-1:0] mid,
  input  logic [bbd_pkg::PIX_W-1:0] pix,
  input  logic                      border,
  input  logic                      blue_row,
  input  logic                      is_green,
  output bbd_pkg::rgb_t             rgb
);

  localparam int PW = bbd_pkg::PIX_W;

  logic [PW-1:0] win_r   [3][3];
  logic [PW-1:0] win_nxt [3][3];
  logic [PW:0]   hor_sum, ver_sum;
  logic [PW+1:0] edg_sum, dia_sum;
  logic [PW-1:0] ctr, hor, ver, edg_mean, dia_mean;

  // Shift left by one column, new column from the two lines and the input
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = top;
    win_nxt[1][2] = mid;
    win_nxt[2][2] = pix;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (shift_en) begin
      win_r <= win_nxt;
    end
  end

  // Rounded means over the updated window
  always_comb begin
    ctr      = win_nxt[1][1];
    hor_sum  = (PW+1)'(win_nxt[1][0]) + (PW+1)'(win_nxt[1][2]) + (PW+1)'(1);
    ver_sum  = (PW+1)'(win_nxt[0][1]) + (PW+1)'(win_nxt[2][1]) + (PW+1)'(1);
    edg_sum  = (PW+2)'(win_nxt[0][1]) + (PW+2)'(win_nxt[1][0]) +
               (PW+2)'(win_nxt[1][2]) + (PW+2)'(win_nxt[2][1]) + (PW+2)'(2);
    dia_sum  = (PW+2)'(win_nxt[0][0]) + (PW+2)'(win_nxt[0][2]) +
               (PW+2)'(win_nxt[2][0]) + (PW+2)'(win_nxt[2][2]) + (PW+2)'(2);
    hor      = hor_sum[PW:1];
    ver      = ver_sum[PW:1];
    edg_mean = edg_sum[PW+1:2];
    dia_mean = dia_sum[PW+1:2];
  end

  // Color assignment by site class
  always_comb begin
    rgb = '0;
    if (!border) begin
      if (is_green) begin
        rgb.green = ctr;
        if (blue_row) begin
          rgb.blue = hor;
          rgb.red  = ver;
        end else begin
          rgb.red  = hor;
          rgb.blue = ver;
        end
      end else begin
        rgb.green = edg_mean;
        if (blue_row) begin
          rgb.blue = ctr;
          rgb.red  = dia_mean;
        end else begin
          rgb.red  = ctr;
          rgb.blue = dia_mean;
        end
      end
    end
  end

endmodule

// File: rtl/bayer_bilinear_demosaic.sv
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic
// Streaming 3x3 bilinear demosaic of 8-bit raw Bayer pixels.
//
//   channel   dir  handshake           payload
//   in_ch     in   valid/ready         raw_pixel[7:0], blank_tick
//   out_ch    out  valid/ready         red, green, blue [7:0], frame_end
//   APB       in   psel/penable/pready paddr[3:0], pwdata/prdata[31:0]
//
// One item per cycle sustained while out_ch.ready is high and in_ch.ready is
// not held off. The line stores are read at the edge that accepts an item.
// At the edge where stage 1 advances, the window shifts, the line stores are
// written and the result lands in the output register. Stage 1 holds the
// item while the registered line-store reads complete. Output stalls back up
// through the single internal stage to in_ch.ready. in_ch.ready is low after
// reset and in the cycle after a register write, while area is recomputed.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic (
  input  logic                       clk,
  input  logic                       rst_n,
  bbd_in_if.sink                     in_ch,
  bbd_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bbd_pkg::APB_AW-1:0] paddr,
  input  logic [bbd_pkg::APB_DW-1:0] pwdata,
  output logic [bbd_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  bbd_pkg::cfg_t              cfg;
  logic                       cfg_busy;
  bbd_pkg::pos_info_t         pos_info;
  logic                       in_acc;
  logic                       adv;
  logic [bbd_pkg::PIX_W-1:0]  pix_in;

  // Stage 1: item waiting for line-store data
  logic                       s1_valid_r;
  bbd_pkg::pos_info_t         s1_info_r;
  logic [bbd_pkg::PIX_W-1:0]  s1_pix_r;
  logic                       s1_byp_r;
  logic [bbd_pkg::PIX_W-1:0]  s1_byp_top_r;
  logic [bbd_pkg::PIX_W-1:0]  s1_byp_mid_r;
  logic [bbd_pkg::PIX_W-1:0]  older_rd, newer_rd;
  logic [bbd_pkg::PIX_W-1:0]  top_eff, mid_eff;
  logic                       byp_nxt;

  // Result register
  logic                       out_valid_r;
  bbd_pkg::rgb_t              out_rgb_r;
  logic                       out_last_r;
  bbd_pkg::rgb_t              rgb;

  bbd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .busy    (cfg_busy)
  );

  // Handshake
  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !cfg_busy && (!s1_valid_r || adv);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign pix_in      = in_ch.blank_tick ? '0 : in_ch.raw_pixel;

  bbd_pos_ctrl u_pos (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_acc),
    .cfg    (cfg),
    .info   (pos_info)
  );

  // Forward the stage-1 write when the next item hits the same column
  assign top_eff = s1_byp_r ? s1_byp_top_r : older_rd;
  assign mid_eff = s1_byp_r ? s1_byp_mid_r : newer_rd;
  assign byp_nxt = adv && (pos_info.addr == s1_info_r.addr);

  bbd_line_ram u_older (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (pos_info.addr),
    .rd_data (older_rd),
    .wr_en   (adv),
    .wr_addr (s1_info_r.addr),
    .wr_data (mid_eff)
  );

  bbd_line_ram u_newer (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (pos_info.addr),
    .rd_data (newer_rd),
    .wr_en   (adv),
    .wr_addr (s1_info_r.addr),
    .wr_data (s1_pix_r)
  );

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_info_r    <= pos_info;
      s1_pix_r     <= pix_in;
      s1_byp_r     <= byp_nxt;
      s1_byp_top_r <= mid_eff;
      s1_byp_mid_r <= s1_pix_r;
    end
  end

  bbd_window u_win (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (adv),
    .top      (top_eff),
    .mid      (mid_eff),
    .pix      (s1_pix_r),
    .border   (s1_info_r.border),
    .blue_row (s1_info_r.blue_row),
    .is_green (s1_info_r.is_green),
    .rgb      (rgb)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s1_info_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_info_r.emit) begin
      out_rgb_r  <= rgb;
      out_last_r <= s1_info_r.last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.red       = out_rgb_r.red;
  assign out_ch.green     = out_rgb_r.green;
  assign out_ch.blue      = out_rgb_r.blue;
  assign out_ch.frame_end = out_last_r;

endmodule

// File: rtl/bbd_checker.sv
// ----------------------------------------------------------------------------
// bbd_checker
// Port-level checks of the demosaic block, bound to the top level.
// ----------------------------------------------------------------------------
module bbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic       frame_end,
  input logic       psel,
  input logic       penable,
  input logic       pwrite
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) &&
    $stable(blue) && $stable(frame_end))
    else $error("result changed while stalled");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A new result must trace back to an accepted item
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching item");

  // Input is held off the cycle after a register write
  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite |=> !in_ready)
    else $error("input taken while geometry settles");

endmodule

bind bayer_bilinear_demosaic bbd_checker u_bbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .red       (out_ch.red),
  .green     (out_ch.green),
  .blue      (out_ch.blue),
  .frame_end (out_ch.frame_end),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite)
);
